// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Cell index width for the largest screen, 128 x 32 cells
	localparam int CELL_AW = 12;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ERROR   = 8'h45;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

	// Register select, taken from paddr[2]
	localparam logic REG_DEFAULT_ATTR = 1'b0;
	localparam logic REG_ERROR_ATTR   = 1'b1;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_MARK,
		OP_MOVE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CELL_AW-1:0] addr;
		logic [15:0]        cell_data;
		logic [6:0]         col;
		logic [4:0]         row;
		logic               scrolled;
		logic               perr;
	} job_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_EXEC,
		B_FILL,
		B_SCROLL,
		B_FINISH
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/tcw_front.sv =====
// Front end: accepts words, tracks the cursor and turns each word into a buffer job.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       kind,
	input  wire logic [7:0] symbol,
	input  wire logic [7:0] attribute,
	input  wire logic       use_position,
	input  wire logic [6:0] column,
	input  wire logic [4:0] row_index,
	input  wire logic [7:0] default_attr,
	input  wire logic [7:0] error_attr,
	input  wire logic       q_full,
	input  wire logic       init_busy,
	output logic            push,
	output job_t            push_job
);

	localparam int CELLS = COLUMNS * ROWS;

	logic [6:0] col_q;
	logic [4:0] row_q;

	assign in_stall = q_full | init_busy;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		logic       bad;
		logic [6:0] pc;
		logic [4:0] pr;
		logic [7:0] nc;
		logic [5:0] nr;
		logic [7:0] attr_sel;
		bad      = use_position & (({1'b0, column} >= 8'(COLUMNS)) |
		                           ({1'b0, row_index} >= 6'(ROWS)));
		pc       = use_position ? column : col_q;
		pr       = use_position ? row_index : row_q;
		attr_sel = (attribute != 8'd0) ? attribute : default_attr;
		nc       = 8'd0;
		nr       = 6'd0;
		push_job = '0;
		if (kind) begin
			push_job.op        = OP_CLEAR;
			push_job.cell_data = {default_attr, CH_SPACE};
		end else if (bad) begin
			push_job.op        = OP_MARK;
			push_job.addr      = CELL_AW'(CELLS - 1);
			push_job.cell_data = {error_attr, CH_ERROR};
			push_job.col       = col_q;
			push_job.row       = row_q;
			push_job.perr      = 1'b1;
		end else begin
			push_job.addr      = CELL_AW'(pr) * CELL_AW'(COLUMNS) + CELL_AW'(pc);
			push_job.cell_data = {attr_sel, symbol};
			if (symbol == CH_NEWLINE) begin
				push_job.op = OP_MOVE;
				nc = 8'd0;
				nr = {1'b0, pr} + 6'd1;
			end else begin
				push_job.op = OP_PUT;
				if ({1'b0, pc} + 8'd1 == 8'(COLUMNS)) begin
					nc = 8'd0;
					nr = {1'b0, pr} + 6'd1;
				end else begin
					nc = {1'b0, pc} + 8'd1;
					nr = {1'b0, pr};
				end
			end
			// ran off the bottom: screen moves up, cursor stays on the last row
			if (nr == 6'(ROWS)) begin
				push_job.scrolled = 1'b1;
				nr = 6'(ROWS - 1);
			end
			push_job.col = nc[6:0];
			push_job.row = nr[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			col_q <= push_job.col;
			row_q <= push_job.row;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tcw_queue.sv =====
// Two-entry job queue between the front end and the buffer engine.
`default_nettype none

module tcw_queue import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	input  wire logic pop,
	output job_t      pop_job,
	output logic      full,
	output logic      empty
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// ===== sv/tcw_back.sv =====
// Buffer engine: owns the cell memory, runs cell writes, scroll and clear, drives results.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  job_t      q_job,
	output logic      pop,
	output logic      init_busy,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [6:0] cursor_column,
	output logic [4:0] cursor_row,
	output logic       scrolled,
	output logic       position_error
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [15:0] mem [CELLS];
	logic [15:0] rd_q;

	back_state_t state_q, state_d;
	logic [AW-1:0] cnt_q, cnt_d;
	job_t job_q;

	// scroll copy: read issued one cycle, written back the next
	logic          wr_s1;
	logic [AW-1:0] waddr_s1;
	logic          zero_s1;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic          issue;
	logic          zero_c;
	logic          last_c;
	logic          out_load;
	logic          out_valid_q;

	assign zero_c    = cnt_q >= AW'(CELLS - COLUMNS);
	assign last_c    = cnt_q == AW'(CELLS - 1);
	assign init_busy = state_q == B_INIT;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = cnt_q;
		wdata    = '0;
		re       = 1'b0;
		raddr    = cnt_q + AW'(COLUMNS);
		issue    = 1'b0;
		out_load = 1'b0;
		if (wr_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = zero_s1 ? 16'd0 : rd_q;
		end
		case (state_q)
			B_INIT: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = 16'd0;
				if (last_c) begin
					cnt_d   = '0;
					state_d = B_IDLE;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				cnt_d = '0;
				case (job_q.op)
					OP_PUT, OP_MARK: begin
						we      = 1'b1;
						waddr   = job_q.addr[AW-1:0];
						wdata   = job_q.cell_data;
						state_d = job_q.scrolled ? B_SCROLL : B_FINISH;
					end
					OP_MOVE: begin
						state_d = job_q.scrolled ? B_SCROLL : B_FINISH;
					end
					OP_CLEAR: begin
						state_d = B_FILL;
					end
					default: begin
						state_d = B_FINISH;
					end
				endcase
			end
			B_FILL: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = job_q.cell_data;
				if (last_c) begin
					state_d = B_FINISH;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			B_SCROLL: begin
				issue = 1'b1;
				re    = ~zero_c;
				if (last_c) begin
					state_d = B_FINISH;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			B_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q       <= cnt_d;
			wr_s1       <= issue;
			out_valid_q <= out_load | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= cnt_q;
		zero_s1  <= zero_c;
		if (pop) begin
			job_q <= q_job;
		end
		if (out_load) begin
			cursor_column  <= job_q.col;
			cursor_row     <= job_q.row;
			scrolled       <= job_q.scrolled;
			position_error <= job_q.perr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Path of a print without scroll: queue slot, engine states IDLE, EXEC and FINISH, result registers.
// The buffer engine runs one word at a time in a fetch, write, retire sequence; a scroll
//   adds a copy pass over all cells (one cell copy a cycle), a clear a fill pass over all cells.
// The front end takes up to two more words into its queue while the engine works.
// Reset: a zeroing pass runs over every cell of the cell memory, input stalled.
// Registers reset to default attribute 15 and error attribute 244; cursor homes to 0,0.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  symbol,
	input  wire logic [7:0]  attribute,
	input  wire logic        use_position,
	input  wire logic [6:0]  column,
	input  wire logic [4:0]  row_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       cursor_column,
	output logic [4:0]       cursor_row,
	output logic             scrolled,
	output logic             position_error
);

	logic [7:0] default_attr_q;
	logic [7:0] error_attr_q;
	logic       reg_wr;
	logic       q_full;
	logic       q_empty;
	logic       push;
	logic       pop;
	logic       init_busy;
	job_t       push_job;
	job_t       pop_job;

	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[2])
			REG_DEFAULT_ATTR: prdata = {24'd0, default_attr_q};
			REG_ERROR_ATTR:   prdata = {24'd0, error_attr_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEFAULT_ATTR_RST;
			error_attr_q   <= ERROR_ATTR_RST;
		end else if (reg_wr) begin
			if (paddr[2] == REG_DEFAULT_ATTR) begin
				default_attr_q <= pwdata[7:0];
			end
			if (paddr[2] == REG_ERROR_ATTR) begin
				error_attr_q <= pwdata[7:0];
			end
		end
	end

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.symbol      (symbol),
		.attribute   (attribute),
		.use_position(use_position),
		.column      (column),
		.row_index   (row_index),
		.default_attr(default_attr_q),
		.error_attr  (error_attr_q),
		.q_full      (q_full),
		.init_busy   (init_busy),
		.push        (push),
		.push_job    (push_job)
	);

	tcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.full    (q_full),
		.empty   (q_empty)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (pop_job),
		.pop           (pop),
		.init_busy     (init_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row),
		.scrolled      (scrolled),
		.position_error(position_error)
	);

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, cursor_column} < 8'(COLUMNS)) &&
		              ({1'b0, cursor_row} < 6'(ROWS)))
		else $error("result cursor lies off screen");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> (cursor_row == 5'(ROWS - 1)) && !position_error)
		else $error("scroll result without cursor on last row");

	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !(in_valid && !in_stall))
		else $error("word accepted during memory zeroing pass");

endmodule

`default_nettype wire
